[hdl/bed_pkg.sv]
// Package with the mode type, character codes and byte maps of the escape decoder.
`default_nettype none
package bed_pkg;

    localparam int unsigned ByteW = 8;

    typedef logic [ByteW-1:0] t_byte;

    typedef enum logic [1:0] {
        MODE_LITERAL    = 2'd0,
        MODE_ESCAPE     = 2'd1,
        MODE_HEX_FIRST  = 2'd2,
        MODE_HEX_SECOND = 2'd3
    } t_mode;

    localparam t_byte CH_BACKSLASH = 8'h5C;
    localparam t_byte CH_ZERO      = 8'h30;
    localparam t_byte CH_NINE      = 8'h39;
    localparam t_byte CH_LOWER_A   = 8'h61;
    localparam t_byte CH_LOWER_X   = 8'h78;
    localparam t_byte HEX_TEN      = 8'd10;

    // Everything the decode step hands back to the top level.
    typedef struct packed {
        logic  out_valid;
        t_byte out_byte;
        t_mode next_mode;
        logic  load_high;
    } t_dec_res;

    function automatic t_byte nibble_of(input t_byte b);
        t_byte val;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            val = b - CH_ZERO;
        end else begin
            val = b - CH_LOWER_A + HEX_TEN;
        end
        return val;
    endfunction

    function automatic t_byte escape_map(input t_byte b);
        t_byte val;
        unique case (b)
            8'h73:   val = 8'd32;
            8'h61:   val = 8'd7;
            8'h62:   val = 8'd8;
            8'h66:   val = 8'd12;
            8'h76:   val = 8'd11;
            8'h72:   val = 8'd13;
            8'h6E:   val = 8'd10;
            8'h74:   val = 8'd9;
            default: val = b;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

[hdl/bed_decode.sv]
// Combinational decode of one byte against the current mode and held hex digit.
`default_nettype none
module bed_decode (
    input  var bed_pkg::t_mode    i_mode,
    input  var bed_pkg::t_byte    i_high,
    input  var bed_pkg::t_byte    i_byte,
    input  var logic              i_last,
    output var bed_pkg::t_dec_res o_res
);
    import bed_pkg::*;

    t_byte w_hi_nib;
    t_byte w_lo_nib;
    t_byte w_hex_byte;

    assign w_hi_nib   = nibble_of(i_high);
    assign w_lo_nib   = nibble_of(i_byte);
    assign w_hex_byte = {w_hi_nib[3:0], 4'b0000} + w_lo_nib;

    always_comb begin
        o_res.out_valid = 1'b0;
        o_res.out_byte  = '0;
        o_res.next_mode = MODE_LITERAL;
        o_res.load_high = 1'b0;
        unique case (i_mode)
            MODE_LITERAL: begin
                if (i_byte == CH_BACKSLASH) begin
                    o_res.next_mode = i_last ? MODE_LITERAL : MODE_ESCAPE;
                end else begin
                    o_res.out_valid = 1'b1;
                    o_res.out_byte  = i_byte;
                end
            end
            MODE_ESCAPE: begin
                if (i_byte == CH_LOWER_X) begin
                    o_res.next_mode = i_last ? MODE_LITERAL : MODE_HEX_FIRST;
                end else begin
                    o_res.out_valid = 1'b1;
                    o_res.out_byte  = escape_map(i_byte);
                end
            end
            MODE_HEX_FIRST: begin
                // A string that ends here drops the escape and decodes this byte as literal.
                if (i_last) begin
                    if (i_byte != CH_BACKSLASH) begin
                        o_res.out_valid = 1'b1;
                        o_res.out_byte  = i_byte;
                    end
                end else begin
                    o_res.load_high = 1'b1;
                    o_res.next_mode = MODE_HEX_SECOND;
                end
            end
            MODE_HEX_SECOND: begin
                o_res.out_valid = 1'b1;
                o_res.out_byte  = w_hex_byte;
            end
            default: begin
                o_res.out_valid = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

[hdl/backslash_escape_decoder_top.sv]
// Top level of the backslash escape decoder: input register, decode, result register.
// A request goes through the input register and then the result register.
// Throughput: one request per cycle while the result is not held; the mode
// register updates as a request moves from the input register into the
// result register. Reset (synchronous, active low) empties both registers
// and returns the mode to literal with the held hex digit cleared.
`default_nettype none
module backslash_escape_decoder_top (
    input  var logic          i_clk,
    input  var logic          i_rst_n,
    input  var logic          i_valid,
    output var logic          o_stall,
    input  var bed_pkg::t_byte i_in_byte,
    input  var logic          i_in_last,
    output var logic          o_valid,
    input  var logic          i_stall,
    output var logic          o_out_valid,
    output var bed_pkg::t_byte o_out_byte,
    output var logic          o_out_end
);
    import bed_pkg::*;

    logic     r_in_vld;
    t_byte    r_in_byte;
    logic     r_in_last;
    logic     r_out_vld;
    logic     r_out_valid;
    t_byte    r_out_byte;
    logic     r_out_end;
    t_mode    r_mode;
    t_mode    n_mode;
    t_byte    r_high;
    t_byte    n_high;
    t_dec_res w_res;
    logic     w_advance;
    logic     w_accept;

    bed_decode u_decode (
        .i_mode (r_mode),
        .i_high (r_high),
        .i_byte (r_in_byte),
        .i_last (r_in_last),
        .o_res  (w_res)
    );

    // The input register drains whenever the result register is free or being taken.
    assign w_advance = r_in_vld && !(r_out_vld && i_stall);
    assign o_stall   = r_in_vld && !w_advance;
    assign w_accept  = i_valid && !o_stall;

    always_comb begin
        n_mode = r_mode;
        n_high = r_high;
        if (w_advance) begin
            n_mode = w_res.next_mode;
            if (w_res.load_high) begin
                n_high = r_in_byte;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_mode    <= MODE_LITERAL;
            r_high    <= '0;
        end else begin
            r_mode <= n_mode;
            r_high <= n_high;
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_advance) begin
                r_in_vld <= 1'b0;
            end
            if (w_advance) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
        if (w_advance) begin
            r_out_valid <= w_res.out_valid;
            r_out_byte  <= w_res.out_byte;
            r_out_end   <= r_in_last;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_end   = r_out_end;

endmodule
`default_nettype wire

[hdl/bed_checker.sv]
// Port-level checker for the escape decoder, bound to the top level.
`default_nettype none
module bed_checker (
    input var logic          i_clk,
    input var logic          i_rst_n,
    input var logic          i_valid,
    input var logic          o_stall,
    input var logic          o_valid,
    input var logic          i_stall,
    input var logic          o_out_valid,
    input var bed_pkg::t_byte o_out_byte,
    input var logic          o_out_end
);

    // A held result keeps its payload until it is taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_valid) && $stable(o_out_byte)
            && $stable(o_out_end))
        else $error("result changed while stalled");

    // The decoder only pushes back when its result register is blocked.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without a blocked result");

    // A result without a decoded byte carries a zero byte.
    a_zero_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_out_valid |-> o_out_byte == 8'd0)
        else $error("empty result carries a nonzero byte");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result pending after reset");

    // With nothing in flight, an accepted request cannot produce a result at the next edge.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid && !o_stall && !i_valid ##1 i_valid && !o_valid |=> !o_valid)
        else $error("result appeared too early");

endmodule

bind backslash_escape_decoder_top bed_checker u_bed_checker (.*);
`default_nettype wire

[bench/backslash_escape_decoder_top_test.sv]
// Self-checking testbench for the backslash escape decoder: random and directed strings, scoreboard.
`timescale 1ns / 100ps
module backslash_escape_decoder_top_test;
    import bed_pkg::*;

    localparam int RANDOM_REQUESTS  = 1600;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 10;
    localparam int LONG_HOLD_AT     = 700;
    localparam int LONG_HOLD_CYCLES = 250;

    localparam t_byte ESC_LETTERS [9] = '{"s", "a", "b", "f", "v", "r", "n", "t", CH_BACKSLASH};

    typedef struct {
        t_byte data;
        logic  is_last;
        bit    drain_first;
    } t_request;

    typedef struct {
        logic  has_byte;
        t_byte data;
        logic  end_mark;
    } t_decoded;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    t_byte i_in_byte = '0;
    logic  i_in_last = 1'b0;
    logic  i_stall = 1'b0;
    logic  o_stall;
    logic  o_valid;
    logic  o_out_valid;
    t_byte o_out_byte;
    logic  o_out_end;

    t_request request_q[$];
    t_decoded decoded_q[$];
    t_byte    text_buf[$];

    // Predictor state.
    t_mode decode_mode = MODE_LITERAL;
    t_byte held_digit = '0;

    bit in_fire = 1'b0;
    bit out_fire = 1'b0;
    int n_sent = 0;
    int n_strings = 0;
    int n_results = 0;
    int n_bytes_out = 0;
    int n_input_stalls = 0;
    int mismatches = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit long_hold_done = 1'b0;

    backslash_escape_decoder_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_byte   (i_in_byte),
        .i_in_last   (i_in_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_valid (o_out_valid),
        .o_out_byte  (o_out_byte),
        .o_out_end   (o_out_end)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_byte hex_value(input t_byte b);
        if (b >= CH_ZERO && b <= CH_NINE) begin
            return b - CH_ZERO;
        end
        return b - CH_LOWER_A + HEX_TEN;
    endfunction

    function automatic t_byte escape_char(input t_byte b);
        case (b)
            "s":     return 8'd32;
            "a":     return 8'd7;
            "b":     return 8'd8;
            "f":     return 8'd12;
            "v":     return 8'd11;
            "r":     return 8'd13;
            "n":     return 8'd10;
            "t":     return 8'd9;
            default: return b;
        endcase
    endfunction

    // Works out the decoded result of one accepted request and advances the mode.
    task automatic predict_decode(input t_byte b, input logic last);
        t_decoded res;
        t_mode    cur;
        bit       plain;
        cur = decode_mode;
        res = '{has_byte: 1'b0, data: '0, end_mark: last};
        decode_mode = MODE_LITERAL;
        // A last byte right after \x abandons the escape and is read as a plain byte.
        plain = (cur == MODE_LITERAL) || (cur == MODE_HEX_FIRST && last);
        if (plain) begin
            if (b == CH_BACKSLASH) begin
                if (!last) decode_mode = MODE_ESCAPE;
            end else begin
                res.has_byte = 1'b1;
                res.data = b;
            end
        end else begin
            case (cur)
                MODE_ESCAPE: begin
                    if (b == CH_LOWER_X) begin
                        if (!last) decode_mode = MODE_HEX_FIRST;
                    end else begin
                        res.has_byte = 1'b1;
                        res.data = escape_char(b);
                    end
                end
                MODE_HEX_FIRST: begin
                    held_digit = b;
                    decode_mode = MODE_HEX_SECOND;
                end
                default: begin
                    res.has_byte = 1'b1;
                    res.data = (hex_value(held_digit) << 4) + hex_value(b);
                end
            endcase
        end
        if (last) decode_mode = MODE_LITERAL;
        decoded_q.insert(decoded_q.size(), res);
    endtask

    // Two stretches of the run draw no random gaps or stalls on either side.
    function automatic bit calm_zone(input int n);
        return (n >= 300 && n < 450) || (n >= 1100 && n < 1250);
    endfunction

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_byte plain_char();
        t_byte b;
        do begin
            b = t_byte'($urandom_range(0, 255));
        end while (b == CH_BACKSLASH);
        return b;
    endfunction

    function automatic t_byte hex_char();
        int r;
        r = $urandom_range(0, 15);
        return (r < 10) ? t_byte'(CH_ZERO + r) : t_byte'(CH_LOWER_A + r - 10);
    endfunction

    function automatic t_byte any_char();
        return t_byte'($urandom_range(0, 255));
    endfunction

    task automatic add_char(input t_byte c);
        text_buf.insert(text_buf.size(), c);
    endtask

    task automatic add_escape(input t_byte c);
        add_char(CH_BACKSLASH);
        add_char(c);
    endtask

    // Moves the buffered string into the request queue, marking its final byte.
    task automatic queue_text(input bit drain);
        foreach (text_buf[k]) begin
            request_q.insert(request_q.size(),
                             t_request'{data: text_buf[k],
                                        is_last: (k == text_buf.size() - 1),
                                        drain_first: drain && (k == 0)});
        end
        text_buf.delete();
    endtask

    task automatic add_random_string(input bit drain);
        int n_tok;
        int kind;
        n_tok = $urandom_range(1, 8);
        for (int k = 0; k < n_tok; k++) begin
            kind = $urandom_range(0, 99);
            if (kind < 40) begin
                add_char(plain_char());
            end else if (kind < 60) begin
                add_escape(ESC_LETTERS[$urandom_range(0, 8)]);
            end else if (kind < 70) begin
                add_escape(any_char());
            end else if (kind < 90) begin
                add_escape(CH_LOWER_X);
                add_char(hex_char());
                add_char(hex_char());
            end else if (kind < 95) begin
                add_escape(CH_LOWER_X);
                add_char(any_char());
                add_char(any_char());
            end else begin
                add_char(any_char());
            end
        end
        // Some strings end in the middle of an escape.
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
            add_char(CH_BACKSLASH);
        end else if (kind < 10) begin
            add_escape(CH_LOWER_X);
        end else if (kind < 15) begin
            add_escape(CH_LOWER_X);
            add_char(any_char());
        end
        queue_text(drain);
    endtask

    // Sender: presents the head of the request queue, with random gaps between requests.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || in_fire) begin
            if (in_fire) send_gap = pick_gap(calm_zone(n_sent));
            if (send_gap > 0) begin
                send_gap--;
                i_valid <= 1'b0;
            end else if (request_q.size() == 0) begin
                i_valid <= 1'b0;
            end else if (request_q[0].drain_first && decoded_q.size() != 0) begin
                i_valid <= 1'b0;
            end else begin
                i_valid <= 1'b1;
                i_in_byte <= request_q[0].data;
                i_in_last <= request_q[0].is_last;
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off so that the block backs up.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (!long_hold_done && n_sent >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap(calm_zone(n_sent));
            end
        end
    end

    // Monitor and scoreboard, with the watchdog.
    always @(posedge i_clk) begin : monitor
        t_decoded want;
        bit       bad;
        in_fire = i_rst_n && i_valid && !o_stall;
        out_fire = i_rst_n && o_valid && !i_stall;
        if (i_rst_n && i_valid && o_stall) n_input_stalls++;
        if (out_fire) begin
            n_results++;
            if (o_out_valid === 1'b1) n_bytes_out++;
            if (decoded_q.size() == 0) begin
                $display("%0t: result with nothing expected: valid %b byte %h end %b",
                         $time, o_out_valid, o_out_byte, o_out_end);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                bad = 1'b0;
                if (o_out_valid !== want.has_byte) begin
                    $display("%0t: out_valid expected %b actual %b",
                             $time, want.has_byte, o_out_valid);
                    bad = 1'b1;
                end
                if (o_out_byte !== want.data) begin
                    $display("%0t: out_byte expected %h actual %h", $time, want.data, o_out_byte);
                    bad = 1'b1;
                end
                if (o_out_end !== want.end_mark) begin
                    $display("%0t: out_end expected %b actual %b",
                             $time, want.end_mark, o_out_end);
                    bad = 1'b1;
                end
                if (bad) mismatches++;
            end
        end
        if (in_fire) begin
            predict_decode(i_in_byte, i_in_last);
            request_q.delete(0);
            n_sent++;
            if (i_in_last) n_strings++;
        end
        if (in_fire || out_fire) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("backslash_escape_decoder_top verification failed");
            $finish;
        end
    end

    initial begin : stimulus
        int base;
        int n_random_strings;
        // Zero byte, then \x with a letter digit and an all-ones digit that wraps.
        text_buf = '{8'h00, CH_BACKSLASH, CH_LOWER_X, "f", 8'hFF};
        queue_text(1'b0);
        foreach (ESC_LETTERS[k]) add_escape(ESC_LETTERS[k]);
        queue_text(1'b0);
        // Trailing backslash.
        text_buf = '{CH_BACKSLASH};
        queue_text(1'b0);
        // The x of \x as the last byte.
        text_buf = '{CH_BACKSLASH, CH_LOWER_X};
        queue_text(1'b0);
        // Last byte right after \x, plain and then a backslash.
        text_buf = '{CH_BACKSLASH, CH_LOWER_X, "A"};
        queue_text(1'b0);
        text_buf = '{CH_BACKSLASH, CH_LOWER_X, CH_BACKSLASH};
        queue_text(1'b0);

        base = request_q.size();
        n_random_strings = 0;
        while (request_q.size() < base + RANDOM_REQUESTS) begin
            // Now and then the sender waits until every result is back.
            add_random_string(n_random_strings % 40 == 0);
            n_random_strings++;
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (request_q.size() != 0 || decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run covered %0d requests in %0d strings, %0d results checked, %0d with a byte.",
                 n_sent, n_strings, n_results, n_bytes_out);
        $display("Requests were held back by the block on %0d cycles; %0d results mismatched.",
                 n_input_stalls, mismatches);
        if (mismatches == 0) begin
            $display("backslash_escape_decoder_top verification clean");
        end else begin
            $display("backslash_escape_decoder_top verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
hdl/bed_pkg.sv
hdl/bed_decode.sv
hdl/backslash_escape_decoder_top.sv
hdl/bed_checker.sv
bench/backslash_escape_decoder_top_test.sv
